FILE: rtl/core/vtg_pkg.sv
// ----------------------------------------------------------------------------
// Vario tone generator package
// Shared widths, defaults, register indexes and arithmetic constants.
// ----------------------------------------------------------------------------
package vtg_pkg;

  // Default values for the top-level parameters.
  localparam int SAMPLE_RATE_HZ_DEF   = 48000;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int PHASE_BITS_DEF       = 32;

  // Field widths.
  localparam int VARIO_W  = 12;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 12;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIMB = 1'b1;

  localparam int SINK_RESET  = -100;
  localparam int CLIMB_RESET = 10;

  // Serial arithmetic unit widths.
  localparam int MUL_B_W = 16;
  localparam int DIV_D_W = 25;

  // Sine polynomial coefficients in Q15.
  localparam int SIN_A = 51472;
  localparam int SIN_B = 21024;
  localparam int SIN_C = 2320;
  localparam int SIN_MAX = 32767;
  localparam int QUARTER = 16384;

  // Tone schedule, frequencies in 0.1 Hz and durations in ms (D10_* in 0.1 ms).
  localparam int F10_SINK   = 4400;
  localparam int MS_SINK    = 800;
  localparam int MS_MIN     = 50;
  localparam int F10_BASE   = 7500;
  localparam int F10_SLOPE  = 29;
  localparam int F10_MAX    = 22000;
  localparam int D10_BASE   = 4000;
  localparam int D10_SLOPE  = 7;
  localparam int D10_MIN    = 500;
  localparam int TENTHS     = 10;
  localparam int MS_PER_SEC = 1000;

  // Vibrato depth scaling: 0.1% of the step in Q15.
  localparam int VIB_DIVISOR = 32768000;
  localparam int VIB_HALF    = 16384000;
  localparam int VIB_CYCLES  = 3;

endpackage

FILE: rtl/core/vtg_if.sv
// ----------------------------------------------------------------------------
// Vario tone generator channels
// Valid/ready channels for input ticks and output audio samples.
// ----------------------------------------------------------------------------
interface vtg_tick_if;
  logic                                valid;
  logic                                ready;
  logic signed [vtg_pkg::VARIO_W-1:0]  vario;
  logic                                running;

  modport source (output valid, output vario, output running, input ready);
  modport sink (input valid, input vario, input running, output ready);
endinterface

interface vtg_audio_if;
  logic                                valid;
  logic                                ready;
  logic signed [vtg_pkg::SAMPLE_W-1:0] sample;
  logic                                tone_on;
  logic                                period_start;

  modport source (output valid, output sample, output tone_on, output period_start,
                  input ready);
  modport sink (input valid, input sample, input tone_on, input period_start,
                output ready);
endinterface

FILE: rtl/core/vario_tone_generator_core.sv
// ----------------------------------------------------------------------------
// Vario tone generator core: one audio sample per accepted tick.
// Silent ticks outside a period start skip the arithmetic; a tone tick runs 10
// multiplies and 2 divides on the bit-serial units; a period start adds up to 4
// divides and 1 multiply. Sync reset, no clearing pass.
// ----------------------------------------------------------------------------
module vario_tone_generator_core #(
  parameter int SAMPLE_RATE_HZ   = vtg_pkg::SAMPLE_RATE_HZ_DEF,
  parameter int SINE_TABLE_DEPTH = vtg_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS       = vtg_pkg::PHASE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vtg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vtg_pkg::CFG_W-1:0]       cfg_data,
  vtg_tick_if.sink                        tick,
  vtg_audio_if.source                     audio
);

  // Derived sizes. The sine table depth must be a power of two; the block itself
  // does not enforce this. The table index is simply the top bits of the phase word.
  localparam int PB  = PHASE_BITS;
  localparam int BW  = vtg_pkg::MUL_B_W;
  localparam int DW  = PB + BW;
  localparam int DVW = vtg_pkg::DIV_D_W;
  localparam int LD  = $clog2(SINE_TABLE_DEPTH);
  localparam int AMP = SAMPLE_RATE_HZ / 100;

  // Sequencer states. Each arithmetic state launches its unit once and
  // waits for the done pulse before moving on.
  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_START   = 16'h0002,
    S_MS_DIV  = 16'h0004,
    S_FR_MUL  = 16'h0008,
    S_FR_DIV  = 16'h0010,
    S_PS_DIV  = 16'h0020,
    S_VS_DIV  = 16'h0040,
    S_SIN_T2  = 16'h0080,
    S_SIN_P1  = 16'h0100,
    S_SIN_P2  = 16'h0200,
    S_SIN_Y   = 16'h0400,
    S_ENV_MUL = 16'h0800,
    S_ENV_DIV = 16'h1000,
    S_VIB_MUL = 16'h2000,
    S_VIB_DIV = 16'h4000,
    S_DONE    = 16'h8000
  } state_t;

  state_t state;
  logic   issued;

  // Configuration registers.
  logic signed [vtg_pkg::CFG_W-1:0] sink_thr;
  logic signed [vtg_pkg::CFG_W-1:0] climb_thr;

  // Latched tick payload.
  logic signed [vtg_pkg::VARIO_W-1:0] vl;
  logic                               run_l;

  // Architectural state.
  logic [PB-1:0] tone_phase;
  logic [PB-1:0] phase_step;
  logic [PB-1:0] vibrato_phase;
  logic [PB-1:0] vibrato_step;
  logic [15:0]   sample_index;
  logic [15:0]   period_frames;
  logic          beep_toggle;
  logic          tone_active;
  logic          was_running;

  // Working registers of the sequencer.
  logic          tone_pend;
  logic [14:0]   f10;
  logic [10:0]   ms;
  logic [15:0]   frames;
  logic          sin_sel;
  logic [15:0]   t2;
  logic [15:0]   poly;
  logic [14:0]   qs_mag;
  logic          qs_neg;
  logic [14:0]   vs_mag;
  logic          vs_neg;

  // Result being built and the output register.
  logic signed [vtg_pkg::SAMPLE_W-1:0] smp;
  logic                                on_r;
  logic                                ps_r;
  logic                                out_valid;
  logic signed [vtg_pkg::SAMPLE_W-1:0] out_sample;
  logic                                out_tone;
  logic                                out_ps;

  // Shared serial units.
  logic            mul_start;
  logic [PB-1:0]   mul_a;
  logic [BW-1:0]   mul_b;
  logic [DW-1:0]   mul_prod;
  logic            mul_done;
  logic            div_start;
  logic [DW-1:0]   div_dd;
  logic [DVW-1:0]  div_dv;
  logic [DW-1:0]   div_quo;
  logic            div_done;

  vtg_mul #(.A_W(PB), .B_W(BW)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .product(mul_prod), .done(mul_done)
  );

  vtg_div #(.N_W(DW), .D_W(DVW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dd), .divisor(div_dv),
    .quotient(div_quo), .done(div_done)
  );

  // Period decision from the latched climb rate.
  logic               ge_climb;
  logic               le_sink;
  logic signed [17:0] f_raw;
  logic signed [15:0] d10;
  logic [14:0]        f_clamp;
  logic               new_period;

  always_comb begin
    ge_climb = (vl >= climb_thr);
    le_sink  = (vl <= sink_thr);
    f_raw    = 18'(vtg_pkg::F10_BASE) + 18'(vtg_pkg::F10_SLOPE) * 18'(vl);
    d10      = 16'(vtg_pkg::D10_BASE) - 16'(vtg_pkg::D10_SLOPE) * 16'(vl);
    if (f_raw < 18'(vtg_pkg::F10_BASE)) begin
      f_clamp = 15'(vtg_pkg::F10_BASE);
    end else if (f_raw > 18'(vtg_pkg::F10_MAX)) begin
      f_clamp = 15'(vtg_pkg::F10_MAX);
    end else begin
      f_clamp = f_raw[14:0];
    end
    new_period = !was_running || (period_frames == 16'd0) ||
                 (sample_index >= period_frames);
  end

  // Sine front end: quadrant fold of the quantized phase.
  logic [PB-1:0] ph;
  logic [15:0]   u16;
  logic [1:0]    quad;
  logic [14:0]   r15;
  logic [15:0]   t;
  logic [16:0]   y17;
  logic [14:0]   ysat;

  always_comb begin
    ph   = sin_sel ? vibrato_phase : tone_phase;
    u16  = {ph[PB-1 -: LD], {(16-LD){1'b0}}};
    quad = u16[15:14];
    r15  = quad[0] ? (15'(vtg_pkg::QUARTER) - {1'b0, u16[13:0]}) : {1'b0, u16[13:0]};
    t    = {r15, 1'b0};
    y17  = mul_prod[31:15];
    ysat = (y17 > 17'(vtg_pkg::SIN_MAX)) ? 15'(vtg_pkg::SIN_MAX) : y17[14:0];
  end

  // Attack and release envelope.
  logic signed [16:0] n_minus_a;
  logic [15:0]        env;

  always_comb begin
    n_minus_a = $signed({1'b0, period_frames}) - 17'sd1 * 17'(AMP);
    if (sample_index < 16'(AMP)) begin
      env = sample_index;
    end else if ($signed({1'b0, sample_index}) > n_minus_a) begin
      env = period_frames - sample_index;
    end else begin
      env = 16'(AMP);
    end
  end

  // Frame count with saturation (zero becomes one) and the signed vibrato offset.
  logic [15:0] frames_q;
  logic [PB-1:0] vib_q;

  always_comb begin
    if (|div_quo[DW-1:16]) begin
      frames_q = 16'hFFFF;
    end else if (div_quo[15:0] == 16'd0) begin
      frames_q = 16'd1;
    end else begin
      frames_q = div_quo[15:0];
    end
    vib_q = vs_neg ? (~div_quo[PB-1:0] + 1'b1) : div_quo[PB-1:0];
  end

  // Operand selection for the shared units.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_dd = '0;
    div_dv = DVW'(1);
    case (state)
      S_FR_MUL: begin
        mul_a = PB'(SAMPLE_RATE_HZ);
        mul_b = BW'(ms);
      end
      S_SIN_T2: begin
        mul_a = PB'(t);
        mul_b = t;
      end
      S_SIN_P1: begin
        mul_a = PB'(vtg_pkg::SIN_C);
        mul_b = t2;
      end
      S_SIN_P2: begin
        mul_a = PB'(poly);
        mul_b = t2;
      end
      S_SIN_Y: begin
        mul_a = PB'(poly);
        mul_b = t;
      end
      S_ENV_MUL: begin
        mul_a = PB'(qs_mag);
        mul_b = env;
      end
      S_VIB_MUL: begin
        mul_a = phase_step;
        mul_b = {1'b0, vs_mag};
      end
      S_MS_DIV: begin
        div_dd = DW'($unsigned(d10));
        div_dv = DVW'(vtg_pkg::TENTHS);
      end
      S_FR_DIV: begin
        div_dd = mul_prod;
        div_dv = DVW'(vtg_pkg::MS_PER_SEC);
      end
      S_PS_DIV: begin
        div_dd = (DW'(f10) << PB) + DW'(5 * SAMPLE_RATE_HZ);
        div_dv = DVW'(10 * SAMPLE_RATE_HZ);
      end
      S_VS_DIV: begin
        div_dd = (DW'(vtg_pkg::VIB_CYCLES) << PB) + DW'(frames >> 1);
        div_dv = DVW'(frames);
      end
      S_ENV_DIV: begin
        div_dd = mul_prod;
        div_dv = DVW'(2 * AMP);
      end
      S_VIB_DIV: begin
        div_dd = mul_prod + DW'(vtg_pkg::VIB_HALF);
        div_dv = DVW'(vtg_pkg::VIB_DIVISOR);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mul_start = !issued && (state == S_FR_MUL || state == S_SIN_T2 ||
                            state == S_SIN_P1 || state == S_SIN_P2 ||
                            state == S_SIN_Y  || state == S_ENV_MUL ||
                            state == S_VIB_MUL);
    div_start = !issued && (state == S_MS_DIV || state == S_FR_DIV ||
                            state == S_PS_DIV || state == S_VS_DIV ||
                            state == S_ENV_DIV || state == S_VIB_DIV);
  end

  logic unit_done;
  assign unit_done = mul_done || div_done;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sink_thr  <= 12'(vtg_pkg::SINK_RESET);
      climb_thr <= 12'(vtg_pkg::CLIMB_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        vtg_pkg::CFG_SINK:  sink_thr  <= cfg_data;
        vtg_pkg::CFG_CLIMB: climb_thr <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer. A tick is taken only in IDLE; the finished sample waits in
  // the output register, so the next tick can be taken while it is pending.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      issued        <= 1'b0;
      tone_phase    <= '0;
      phase_step    <= '0;
      vibrato_phase <= '0;
      vibrato_step  <= '0;
      sample_index  <= '0;
      period_frames <= '0;
      beep_toggle   <= 1'b0;
      tone_active   <= 1'b0;
      was_running   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // In DONE the output register is reloaded below in the same cycle.
      if (audio.valid && audio.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tick.valid) begin
            vl    <= tick.vario;
            run_l <= tick.running;
            state <= S_START;
          end
        end
        S_START: begin
          smp  <= '0;
          on_r <= 1'b0;
          ps_r <= run_l && new_period;
          if (!run_l) begin
            was_running   <= 1'b0;
            sample_index  <= '0;
            period_frames <= '0;
            tone_active   <= 1'b0;
            state         <= S_DONE;
          end else if (new_period) begin
            if (ge_climb) begin
              tone_pend   <= beep_toggle;
              beep_toggle <= !beep_toggle;
              if (le_sink) begin
                f10   <= 15'(vtg_pkg::F10_SINK);
                ms    <= 11'(vtg_pkg::MS_SINK);
                state <= S_FR_MUL;
              end else begin
                f10 <= f_clamp;
                if (d10 < 16'(vtg_pkg::D10_MIN)) begin
                  ms    <= 11'(vtg_pkg::MS_MIN);
                  state <= S_FR_MUL;
                end else begin
                  state <= S_MS_DIV;
                end
              end
            end else if (le_sink) begin
              tone_pend <= 1'b1;
              f10       <= 15'(vtg_pkg::F10_SINK);
              ms        <= 11'(vtg_pkg::MS_SINK);
              state     <= S_FR_MUL;
            end else begin
              tone_pend   <= 1'b0;
              beep_toggle <= 1'b0;
              ms          <= 11'(vtg_pkg::MS_MIN);
              state       <= S_FR_MUL;
            end
          end else if (tone_active) begin
            sin_sel <= 1'b0;
            state   <= S_SIN_T2;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || audio.ready) begin
            out_valid  <= 1'b1;
            out_sample <= smp;
            out_tone   <= on_r;
            out_ps     <= ps_r;
            if (run_l) begin
              was_running <= 1'b1;
              if (sample_index != 16'hFFFF) begin
                sample_index <= sample_index + 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          // Arithmetic states: launch once, then act on the done pulse.
          if (!issued) begin
            issued <= 1'b1;
          end else if (unit_done) begin
            issued <= 1'b0;
            case (state)
              S_MS_DIV: begin
                ms    <= div_quo[10:0];
                state <= S_FR_MUL;
              end
              S_FR_MUL: state <= S_FR_DIV;
              S_FR_DIV: begin
                frames <= frames_q;
                if (tone_pend) begin
                  state <= S_PS_DIV;
                end else begin
                  period_frames <= frames_q;
                  sample_index  <= '0;
                  tone_active   <= 1'b0;
                  state         <= S_DONE;
                end
              end
              S_PS_DIV: begin
                phase_step <= div_quo[PB-1:0];
                state      <= S_VS_DIV;
              end
              S_VS_DIV: begin
                vibrato_step  <= div_quo[PB-1:0];
                vibrato_phase <= '0;
                period_frames <= frames;
                sample_index  <= '0;
                tone_active   <= 1'b1;
                sin_sel       <= 1'b0;
                state         <= S_SIN_T2;
              end
              S_SIN_T2: begin
                t2    <= mul_prod[30:15];
                state <= S_SIN_P1;
              end
              S_SIN_P1: begin
                poly  <= 16'(vtg_pkg::SIN_B) - mul_prod[30:15];
                state <= S_SIN_P2;
              end
              S_SIN_P2: begin
                poly  <= 16'(vtg_pkg::SIN_A) - mul_prod[30:15];
                state <= S_SIN_Y;
              end
              S_SIN_Y: begin
                if (!sin_sel) begin
                  qs_mag <= ysat;
                  qs_neg <= quad[1];
                  state  <= S_ENV_MUL;
                end else begin
                  vs_mag <= ysat;
                  vs_neg <= quad[1];
                  state  <= S_VIB_MUL;
                end
              end
              S_ENV_MUL: state <= S_ENV_DIV;
              S_ENV_DIV: begin
                smp     <= qs_neg ? -$signed(div_quo[15:0]) : $signed(div_quo[15:0]);
                sin_sel <= 1'b1;
                state   <= S_SIN_T2;
              end
              S_VIB_MUL: state <= S_VIB_DIV;
              S_VIB_DIV: begin
                tone_phase    <= tone_phase + phase_step + vib_q;
                vibrato_phase <= vibrato_phase + vibrato_step;
                on_r          <= 1'b1;
                state         <= S_DONE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  assign tick.ready         = (state == S_IDLE);
  assign audio.valid        = out_valid;
  assign audio.sample       = out_sample;
  assign audio.tone_on      = out_tone;
  assign audio.period_start = out_ps;

`ifndef SYNTHESIS
  // The multiplier only finishes while the sequencer waits on it.
  assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_FR_MUL || state == S_SIN_T2 || state == S_SIN_P1 ||
                  state == S_SIN_P2 || state == S_SIN_Y || state == S_ENV_MUL ||
                  state == S_VIB_MUL))
    else $error("multiplier finished outside a multiply step");

  // A silent period never produces a nonzero sample.
  assert property (@(posedge clk) disable iff (rst)
    (audio.valid && !audio.tone_on) |-> (audio.sample == '0))
    else $error("nonzero sample without a tone");

  // A tone period always has a frame count.
  assert property (@(posedge clk) disable iff (rst)
    tone_active |-> (period_frames != 16'd0))
    else $error("tone active with empty period");
`endif

endmodule

FILE: rtl/core/vtg_mul.sv
// ----------------------------------------------------------------------------
// Vario tone generator serial multiplier
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module vtg_mul #(
  parameter int A_W = vtg_pkg::PHASE_BITS_DEF,
  parameter int B_W = vtg_pkg::MUL_B_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  output logic [A_W+B_W-1:0] product,
  output logic             done
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W+B_W-1:0] p;
  logic [A_W-1:0]     mcand;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [A_W:0]       hi;

  always_comb begin
    hi = {1'b0, p[A_W+B_W-1:B_W]} + (p[0] ? {1'b0, mcand} : {(A_W+1){1'b0}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(B_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p     <= {{A_W{1'b0}}, b};
      mcand <= a;
    end else if (busy) begin
      p <= {hi, p[B_W-1:1]};
    end
  end

  assign product = p;

endmodule

FILE: rtl/core/vtg_div.sv
// ----------------------------------------------------------------------------
// Vario tone generator serial divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vtg_div #(
  parameter int N_W = vtg_pkg::PHASE_BITS_DEF + vtg_pkg::MUL_B_W,
  parameter int D_W = vtg_pkg::DIV_D_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic [N_W-1:0] quotient,
  output logic           done
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   quo;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             ge;

  always_comb begin
    trial = {rem, quo[N_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
      quo <= {quo[N_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule
